>>> hw/rtl/fla_pkg.sv
// ============================================================================
// fla_pkg: shared types and constants of the free-list heap allocator
// Heap geometry, operation and status codes, controller commands and the
// beat formats of the request and response channels.
// ============================================================================
package fla_pkg;

    localparam int HEAP_GRANULES = 4096;
    localparam int GW            = $clog2(HEAP_GRANULES);   // granule index width
    localparam int SW            = GW + 1;                  // block size width
    localparam int SENT_G        = 3;                       // sentinel granules
    localparam int MIN_G         = 4;                       // smallest block

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_NEXT  = 2'd1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_IGN  = 2'd2;

    // Commands from the controller to the datapath.
    localparam logic [3:0] CMD_NOP   = 4'd0;
    localparam logic [3:0] CMD_CLEAR = 4'd1;
    localparam logic [3:0] CMD_LOAD  = 4'd2;
    localparam logic [3:0] CMD_SCAN  = 4'd3;
    localparam logic [3:0] CMD_PICK  = 4'd4;
    localparam logic [3:0] CMD_AW1   = 4'd5;
    localparam logic [3:0] CMD_AW2   = 4'd6;
    localparam logic [3:0] CMD_FHC   = 4'd7;
    localparam logic [3:0] CMD_FFC   = 4'd8;
    localparam logic [3:0] CMD_FPC   = 4'd9;
    localparam logic [3:0] CMD_FN    = 4'd10;
    localparam logic [3:0] CMD_FNC   = 4'd11;
    localparam logic [3:0] CMD_FW    = 4'd12;
    localparam logic [3:0] CMD_POST  = 4'd13;

    typedef struct packed {
        logic        kind;
        logic [15:0] req_bytes;
        logic [14:0] free_addr;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] addr;
        logic [15:0] block_bytes;
    } t_rsp;

    typedef struct packed {
        logic [SW-1:0] sz;
        logic          alc;
    } t_head;

    typedef struct packed {
        logic clr_done;
        logic in_kind;
        logic alloc_bad;
        logic free_bad;
        logic scan_end;
        logic pick_none;
        logic split;
        logic fh_ok;
        logic fp_ok;
        logic n_in;
        logic out_busy;
    } t_dp_sts;

endpackage

>>> hw/rtl/fla_ctrl.sv
// ============================================================================
// fla_ctrl: allocator sequencer
// Steps through clearing, the list walk, splitting and merging, and issues
// one datapath command per cycle.
// ============================================================================
module fla_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  fla_pkg::t_dp_sts   i_sts,
    output logic [3:0]         o_cmd,
    output logic               o_in_stall
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_PICK = 4'd3;
    localparam logic [3:0] S_AW1  = 4'd4;
    localparam logic [3:0] S_AW2  = 4'd5;
    localparam logic [3:0] S_FHC  = 4'd6;
    localparam logic [3:0] S_FFC  = 4'd7;
    localparam logic [3:0] S_FPC  = 4'd8;
    localparam logic [3:0] S_FN   = 4'd9;
    localparam logic [3:0] S_FNC  = 4'd10;
    localparam logic [3:0] S_FW   = 4'd11;
    localparam logic [3:0] S_POST = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = fla_pkg::CMD_NOP;
        case (r_state)
            S_CLR: begin
                o_cmd = fla_pkg::CMD_CLEAR;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = fla_pkg::CMD_LOAD;
                    if (i_sts.in_kind == fla_pkg::KIND_FREE) begin
                        n_state = i_sts.free_bad ? S_POST : S_FHC;
                    end else begin
                        n_state = i_sts.alloc_bad ? S_POST : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd = fla_pkg::CMD_SCAN;
                if (i_sts.scan_end) n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd   = fla_pkg::CMD_PICK;
                n_state = i_sts.pick_none ? S_POST : S_AW1;
            end
            S_AW1: begin
                o_cmd   = fla_pkg::CMD_AW1;
                n_state = i_sts.split ? S_AW2 : S_POST;
            end
            S_AW2: begin
                o_cmd   = fla_pkg::CMD_AW2;
                n_state = S_POST;
            end
            S_FHC: begin
                o_cmd   = fla_pkg::CMD_FHC;
                n_state = i_sts.fh_ok ? S_FFC : S_POST;
            end
            S_FFC: begin
                o_cmd   = fla_pkg::CMD_FFC;
                n_state = i_sts.fp_ok ? S_FPC : S_FN;
            end
            S_FPC: begin
                o_cmd   = fla_pkg::CMD_FPC;
                n_state = S_FN;
            end
            S_FN: begin
                o_cmd   = fla_pkg::CMD_FN;
                n_state = i_sts.n_in ? S_FNC : S_FW;
            end
            S_FNC: begin
                o_cmd   = fla_pkg::CMD_FNC;
                n_state = S_FW;
            end
            S_FW: begin
                o_cmd   = fla_pkg::CMD_FW;
                n_state = S_POST;
            end
            S_POST: begin
                if (!i_sts.out_busy) begin
                    o_cmd   = fla_pkg::CMD_POST;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/fla_dp.sv
// ============================================================================
// fla_dp: allocator datapath
// Header and footer tag memories, the walk and candidate registers, the
// next-fit rover and the result register.
// ============================================================================
module fla_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [3:0]         i_cmd,
    input  fla_pkg::t_req      i_in_item,
    input  logic [1:0]         i_fit_mode,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output fla_pkg::t_rsp      o_out_item,
    output fla_pkg::t_dp_sts   o_sts
);

    localparam int GW = fla_pkg::GW;
    localparam int SW = fla_pkg::SW;

    fla_pkg::t_head head_mem [fla_pkg::HEAP_GRANULES];
    logic [SW-1:0]  foot_mem [fla_pkg::HEAP_GRANULES];

    logic           h_we, f_we;
    logic [GW-1:0]  h_wa, h_ra, f_wa, f_ra;
    fla_pkg::t_head h_wd, h_rd;
    logic [SW-1:0]  f_wd, f_rd;

    logic [GW-1:0]  r_clr, r_g, r_p, r_start, r_rover;
    logic [SW-1:0]  r_need, r_sz, r_ps, r_tot;
    logic           r_fv, r_av, r_bv;
    logic [GW-1:0]  r_fg, r_ag, r_bg;
    logic [SW-1:0]  r_fs, r_as, r_bs;
    fla_pkg::t_rsp  r_res, r_out;
    logic           r_ovalid;

    // Request decode.
    logic [16:0]    req_plus;
    logic [13:0]    need_raw;
    logic           req_small;
    logic [GW-1:0]  in_g;

    // Walk and merge arithmetic.
    logic [SW-1:0]  scan_nxt, fn_n, fw_end, aw_end1, aw_end2, aw_g2, rov_sum, need_f;
    logic           fits, pick_v;
    logic [GW-1:0]  pick_g, ffc_p;
    logic [SW-1:0]  pick_s;
    logic           prev_ok, next_ok;

    assign req_plus  = 17'(i_in_item.req_bytes) + 17'd31;
    assign need_raw  = req_plus[16:3];
    assign req_small = (i_in_item.req_bytes <= 16'd24);
    assign in_g      = i_in_item.free_addr[14:3];

    assign scan_nxt = SW'(r_g) + h_rd.sz;
    assign fn_n     = SW'(r_g) + r_sz;
    assign fw_end   = SW'(r_start) + r_tot - SW'(1);
    assign aw_end1  = SW'(r_g) + r_need - SW'(1);
    assign aw_end2  = SW'(r_g) + r_sz - SW'(1);
    assign aw_g2    = SW'(r_g) + r_need;
    assign need_f   = o_sts.split ? r_need : r_sz;
    assign rov_sum  = SW'(r_g) + need_f;
    assign ffc_p    = r_g - f_rd[GW-1:0];

    assign fits    = (h_rd.sz != '0) && !h_rd.alc && (h_rd.sz >= r_need);
    assign prev_ok = (h_rd.sz == r_ps) && !h_rd.alc;
    assign next_ok = (h_rd.sz != '0) && !h_rd.alc;

    // Placement choice; an unused mode code behaves as best fit.
    always_comb begin
        case (i_fit_mode)
            fla_pkg::FIT_FIRST: begin
                pick_v = r_fv; pick_g = r_fg; pick_s = r_fs;
            end
            fla_pkg::FIT_NEXT: begin
                pick_v = r_av || r_fv;
                pick_g = r_av ? r_ag : r_fg;
                pick_s = r_av ? r_as : r_fs;
            end
            default: begin
                pick_v = r_bv; pick_g = r_bg; pick_s = r_bs;
            end
        endcase
    end

    always_comb begin
        o_sts.clr_done  = (r_clr == GW'(fla_pkg::HEAP_GRANULES - 1));
        o_sts.in_kind   = i_in_item.kind;
        o_sts.alloc_bad = (i_in_item.req_bytes == '0) ||
                          (!req_small && (32'(need_raw) > 32'(fla_pkg::HEAP_GRANULES)));
        o_sts.free_bad  = (i_in_item.free_addr[2:0] != 3'd4) || (in_g == '0);
        o_sts.scan_end  = (h_rd.sz == '0) || scan_nxt[GW];
        o_sts.pick_none = !pick_v;
        o_sts.split     = ((r_sz - r_need) >= SW'(fla_pkg::MIN_G));
        o_sts.fh_ok     = (h_rd.sz != '0) && h_rd.alc;
        o_sts.fp_ok     = (f_rd != '0) && (f_rd <= SW'(r_g));
        o_sts.n_in      = !fn_n[GW];
        o_sts.out_busy  = r_ovalid && i_out_stall;
    end

    // Memory port control.
    always_comb begin
        h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
        f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;
        case (i_cmd)
            fla_pkg::CMD_CLEAR: begin
                h_we = 1'b1;
                h_wa = r_clr;
                f_we = 1'b1;
                f_wa = r_clr;
                if (r_clr == '0) begin
                    h_wd = '{sz: SW'(fla_pkg::SENT_G), alc: 1'b1};
                end else if (r_clr == GW'(fla_pkg::SENT_G)) begin
                    h_wd = '{sz: SW'(fla_pkg::HEAP_GRANULES - fla_pkg::SENT_G), alc: 1'b0};
                end
                if (r_clr == GW'(fla_pkg::SENT_G - 1)) begin
                    f_wd = SW'(fla_pkg::SENT_G);
                end else if (r_clr == GW'(fla_pkg::HEAP_GRANULES - 1)) begin
                    f_wd = SW'(fla_pkg::HEAP_GRANULES - fla_pkg::SENT_G);
                end
            end
            fla_pkg::CMD_LOAD: begin
                h_ra = (i_in_item.kind == fla_pkg::KIND_FREE) ? in_g : GW'(fla_pkg::SENT_G);
            end
            fla_pkg::CMD_SCAN: h_ra = scan_nxt[GW-1:0];
            fla_pkg::CMD_AW1: begin
                h_we = 1'b1;
                h_wa = r_g;
                h_wd = '{sz: need_f, alc: 1'b1};
                f_we = o_sts.split;
                f_wa = aw_end1[GW-1:0];
                f_wd = r_need;
            end
            fla_pkg::CMD_AW2: begin
                h_we = 1'b1;
                h_wa = aw_g2[GW-1:0];
                h_wd = '{sz: r_sz - r_need, alc: 1'b0};
                f_we = 1'b1;
                f_wa = aw_end2[GW-1:0];
                f_wd = r_sz - r_need;
            end
            fla_pkg::CMD_FHC: f_ra = r_g - GW'(1);
            fla_pkg::CMD_FFC: h_ra = ffc_p;
            fla_pkg::CMD_FPC: begin
                h_we = prev_ok;
                h_wa = r_g;
            end
            fla_pkg::CMD_FN: h_ra = fn_n[GW-1:0];
            fla_pkg::CMD_FNC: begin
                h_we = next_ok;
                h_wa = fn_n[GW-1:0];
            end
            fla_pkg::CMD_FW: begin
                h_we = 1'b1;
                h_wa = r_start;
                h_wd = '{sz: r_tot, alc: 1'b0};
                f_we = 1'b1;
                f_wa = fw_end[GW-1:0];
                f_wd = r_tot;
            end
            default: h_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (h_we) head_mem[h_wa] <= h_wd;
        h_rd <= head_mem[h_ra];
    end

    always_ff @(posedge i_clk) begin
        if (f_we) foot_mem[f_wa] <= f_wd;
        f_rd <= foot_mem[f_ra];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_rover  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd == fla_pkg::CMD_CLEAR) r_clr <= r_clr + GW'(1);
            if (i_cmd == fla_pkg::CMD_POST) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd)
                fla_pkg::CMD_AW1: r_rover <= rov_sum[GW-1:0];
                fla_pkg::CMD_FPC: if (prev_ok && r_rover == r_g) r_rover <= r_p;
                fla_pkg::CMD_FNC: begin
                    if (next_ok && r_rover == fn_n[GW-1:0]) r_rover <= r_start;
                end
                default: r_rover <= r_rover;
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd == fla_pkg::CMD_POST) r_out <= r_res;
        case (i_cmd)
            fla_pkg::CMD_LOAD: begin
                r_g    <= (i_in_item.kind == fla_pkg::KIND_FREE) ? in_g
                                                                 : GW'(fla_pkg::SENT_G);
                r_need <= req_small ? SW'(fla_pkg::MIN_G) : SW'(need_raw);
                r_fv   <= 1'b0;
                r_av   <= 1'b0;
                r_bv   <= 1'b0;
                r_res  <= '{status: (i_in_item.kind == fla_pkg::KIND_FREE) ?
                                    fla_pkg::ST_IGN : fla_pkg::ST_FAIL,
                            addr: '0, block_bytes: '0};
            end
            fla_pkg::CMD_SCAN: begin
                if (fits) begin
                    if (!r_fv) begin
                        r_fv <= 1'b1; r_fg <= r_g; r_fs <= h_rd.sz;
                    end
                    if (!r_av && r_g >= r_rover) begin
                        r_av <= 1'b1; r_ag <= r_g; r_as <= h_rd.sz;
                    end
                    if (!r_bv || h_rd.sz < r_bs) begin
                        r_bv <= 1'b1; r_bg <= r_g; r_bs <= h_rd.sz;
                    end
                end
                r_g <= scan_nxt[GW-1:0];
            end
            fla_pkg::CMD_PICK: begin
                r_g  <= pick_g;
                r_sz <= pick_s;
            end
            fla_pkg::CMD_AW1: begin
                r_res <= '{status: fla_pkg::ST_OK, addr: 15'({r_g, 3'b100}),
                           block_bytes: 16'({need_f, 3'b000})};
            end
            fla_pkg::CMD_FHC: begin
                r_sz    <= h_rd.sz;
                r_tot   <= h_rd.sz;
                r_start <= r_g;
                if (o_sts.fh_ok) r_res.block_bytes <= 16'({h_rd.sz, 3'b000});
            end
            fla_pkg::CMD_FFC: begin
                r_p  <= ffc_p;
                r_ps <= f_rd;
            end
            fla_pkg::CMD_FPC: begin
                if (prev_ok) begin
                    r_start <= r_p;
                    r_tot   <= r_tot + r_ps;
                end
            end
            fla_pkg::CMD_FNC: if (next_ok) r_tot <= r_tot + h_rd.sz;
            fla_pkg::CMD_FW:  r_res.status <= fla_pkg::ST_OK;
            default: r_g <= r_g;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

endmodule

>>> hw/rtl/free_list_heap_allocator.sv
// Allocate: accept the request, walk the free list block by block, then choose a block,
// split it when the rest is large enough, write its tags and post the response.
// Free: check the block's header, merge it with a free block before and after it, then write the merged tags and post.
// One request at a time; the next is accepted once the response is posted.
// After reset a clearing pass over every granule writes the initial tags; stall stays high.
// ============================================================================
// free_list_heap_allocator: boundary-tag heap allocator
// Heap of 8-byte granules with first, next and best fit placement, block
// splitting on allocate and neighbour merging on free.
// ============================================================================
module free_list_heap_allocator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // Request channel.
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  fla_pkg::t_req  i_in_item,
    // Response channel.
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output fla_pkg::t_rsp  o_out_item,
    // Configuration port.
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    // The only register, fit_mode, sits at byte address 0 and is decoded from paddr[2] alone;
    // addresses 4 to 7 read as zero and ignore writes.
    localparam logic [2:0] ADDR_FIT_MODE = 3'd0;

    logic [1:0]       r_fit;
    logic [3:0]       cmd;
    fla_pkg::t_dp_sts sts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_FIT_MODE[2]) ? {30'b0, r_fit} : 32'b0;

    // A configuration beat lands when the access phase completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit <= fla_pkg::FIT_FIRST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == ADDR_FIT_MODE[2]) r_fit <= pwdata[1:0];
        end
    end

    // The controller walks the tag memories held in the datapath; they speak
    // only through the command code and the status bundle.
    fla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    fla_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_fit_mode  (r_fit),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_sts       (sts)
    );

endmodule

>>> hw/rtl/fla_chk.sv
// ============================================================================
// fla_chk: port checker for the heap allocator
// Watches the response channel for well-formed results.
// ============================================================================
module fla_chk (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           o_out_valid,
    input  logic           i_out_stall,
    input  fla_pkg::t_rsp  o_out_item
);

    // No response is offered straight after reset.
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("response valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled response changed");

    // Failed and ignored responses carry neither an address nor a size.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != fla_pkg::ST_OK |->
            o_out_item.addr == '0 && o_out_item.block_bytes == '0)
        else $error("failed response has payload");

    // A successful beat is either an allocate with a payload address four
    // bytes into a granule, or a free with address zero.
    a_ok_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == fla_pkg::ST_OK |->
            (o_out_item.addr[2:0] == 3'd4 || o_out_item.addr == '0) &&
            o_out_item.block_bytes[2:0] == 3'd0 && o_out_item.block_bytes != '0)
        else $error("bad successful response");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status == fla_pkg::ST_OK ||
                        o_out_item.status == fla_pkg::ST_FAIL ||
                        o_out_item.status == fla_pkg::ST_IGN)
        else $error("unknown status code");

endmodule

bind free_list_heap_allocator fla_chk u_fla_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
